@@ hw/rtl/remote_control_frame_decoder_macros.svh @@
// Assertion macros shared by the remote-control frame decoder.
`ifndef REMOTE_CONTROL_FRAME_DECODER_MACROS_SVH
`define REMOTE_CONTROL_FRAME_DECODER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RCFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rcfd_pkg.sv @@
// Package with constants and types of the remote-control frame decoder.
package rcfd_pkg;
  localparam int unsigned WinLen = 12;
  localparam int unsigned IdxW = 4;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] HdrA = 8'h7F;
  localparam logic [7:0] HdrB = 8'h8F;
  localparam logic [7:0] KindJoy = 8'h0D;
  localparam logic [7:0] KindBtn = 8'h0C;
  localparam logic [7:0] KindKnob = 8'h09;
  localparam logic [1:0] FkJoy = 2'd0;
  localparam logic [1:0] FkBtn = 2'd1;
  localparam logic [1:0] FkKnob = 2'd2;
  localparam logic [8:0] KnobFull = 9'd480;
  localparam logic [7:0] KnobUpperRst = 8'd10;
  localparam logic [7:0] KnobLowerRst = 8'd5;
  localparam logic CfgKnobUpper = 1'b0;
  localparam logic CfgKnobLower = 1'b1;

  // Request from the sequencer to the CRC unit, and its answer.
  typedef struct packed {
    logic       start;
    logic [3:0] count;
  } crc_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] crc;
  } crc_rsp_t;

  // One CRC-8 byte step, eight bit shifts of the right-shifting form.
  function automatic logic [7:0] crc_byte(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    c = c_in ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage

@@ hw/rtl/rcfd_crc.sv @@
// Iterative CRC-8 unit that takes one window byte per cycle.
module rcfd_crc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcfd_pkg::crc_req_t    req_i,
  output logic [3:0]            rd_idx_o,
  input  logic [7:0]            rd_byte_i,
  output rcfd_pkg::crc_rsp_t    rsp_o
);
  logic       busy_q, busy_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] crc_q, crc_d;
  logic       done_q, done_d;

  assign rd_idx_o = idx_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      cnt_d  = req_i.count;
      crc_d  = '0;
    end else if (busy_q) begin
      crc_d = rcfd_pkg::crc_byte(crc_q, rd_byte_i);
      idx_d = idx_q + 4'd1;
      if (idx_q + 4'd1 == cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      crc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.crc  = crc_q;
endmodule

@@ hw/rtl/remote_control_frame_decoder.sv @@
// Top level of the remote-control frame decoder: window, sequencer and result register.
//
//  channel | direction | handshake                    | payload
//  rx      | in        | rx_valid_i / rx_stall_o      | rx_byte_i
//  frame   | out       | frame_valid_o / frame_stall_i | axes, buttons, source, kind, check_ok
//  cfg     | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// A byte that leaves the window short of full is taken with no stall after it.
// A byte that completes a window with a bad header or kind stalls the input
// while it is decoded and while the front byte is dropped. A frame check stalls
// the input through a decode step, the CRC over the bytes before the check byte
// and collection of the sum, an apply step, a shift that drops each frame byte
// and an output step. The output step waits while the previous result still
// sits under stall. Reset is asynchronous and active low and clears the window
// fill, the axes and the buttons.
module remote_control_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               frame_valid_o,
  input  logic               frame_stall_i,
  output logic signed [16:0] axis_left_x_o,
  output logic signed [16:0] axis_left_y_o,
  output logic signed [16:0] axis_right_x_o,
  output logic signed [16:0] axis_right_y_o,
  output logic signed [9:0]  axis_camera_o,
  output logic signed [9:0]  axis_linear_o,
  output logic [11:0]        button_bits_o,
  output logic               frame_source_o,
  output logic [1:0]         frame_kind_o,
  output logic               check_ok_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);
  typedef enum logic [2:0] {StIdle, StDecode, StCrc, StApply, StShift, StOut} state_e;

  state_e      state_q;
  logic [7:0]  win_q [rcfd_pkg::WinLen];
  logic [3:0]  fill_q;
  logic [3:0]  shift_q;
  logic [3:0]  len_q;
  logic [1:0]  kind_q;
  logic        src_q;
  logic        ok_q;
  logic        emit_q;
  logic [7:0]  upper_q, lower_q;
  logic signed [16:0] ax_q [4];
  logic signed [9:0]  ax4_q, ax5_q;
  logic [11:0] btn_q;
  logic        out_valid_q;

  // Result register, loaded at the output step so the sequencer can go on.
  logic signed [16:0] out_ax_q [4];
  logic signed [9:0]  out_ax4_q, out_ax5_q;
  logic [11:0] out_btn_q;
  logic        out_src_q;
  logic [1:0]  out_kind_q;
  logic        out_ok_q;
  logic        out_load;

  rcfd_pkg::crc_req_t crc_req;
  rcfd_pkg::crc_rsp_t crc_rsp;
  logic [3:0] crc_idx;

  rcfd_crc u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (crc_req),
    .rd_idx_o (crc_idx),
    .rd_byte_i(win_q[crc_idx]),
    .rsp_o    (crc_rsp)
  );

  assign crc_req.start = (state_q == StDecode) && (win_q[0] == rcfd_pkg::HdrA ||
                         win_q[0] == rcfd_pkg::HdrB) && (win_q[2] == rcfd_pkg::KindJoy ||
                         win_q[2] == rcfd_pkg::KindBtn || win_q[2] == rcfd_pkg::KindKnob);
  assign crc_req.count = (win_q[2] == rcfd_pkg::KindJoy) ? 4'd9 :
                         (win_q[2] == rcfd_pkg::KindBtn) ? 4'd11 : 4'd8;

  // The result register takes a new transaction once the old one has left.
  assign out_load      = (state_q == StOut) && (!out_valid_q || !frame_stall_i);
  assign rx_stall_o    = (state_q != StIdle);
  assign frame_valid_o = out_valid_q;

  // Knob direction: 2'b10 negative, 2'b01 positive, 2'b00 neutral.
  function automatic logic [1:0] kdir(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
    logic [1:0] r;
    r = 2'b00;
    if (v < lo) r = 2'b10;
    else if (v > hi) r = 2'b01;
    return r;
  endfunction

  // Stick value 256*hi + lo - 512, fits 17 bits signed.
  function automatic logic signed [16:0] stick(input logic [7:0] h, input logic [7:0] l);
    return $signed({1'b0, h, l}) - 17'sd512;
  endfunction

  logic [1:0] d6, d3, d5, d4;
  assign d6 = kdir(win_q[6], lower_q, upper_q);
  assign d3 = kdir(win_q[3], lower_q, upper_q);
  assign d5 = kdir(win_q[5], lower_q, upper_q);
  assign d4 = kdir(win_q[4], lower_q, upper_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= rcfd_pkg::KnobUpperRst;
      lower_q <= rcfd_pkg::KnobLowerRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rcfd_pkg::CfgKnobUpper) upper_q <= cfg_data_i;
      else lower_q <= cfg_data_i;
    end
  end

  // Window storage; a drop moves all bytes down by one per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && rx_valid_i && !rx_stall_o) begin
      win_q[fill_q] <= rx_byte_i;
    end else if (state_q == StShift) begin
      for (int i = 0; i < rcfd_pkg::WinLen - 1; i++) win_q[i] <= win_q[i + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      shift_q     <= '0;
      len_q       <= '0;
      kind_q      <= '0;
      src_q       <= 1'b0;
      ok_q        <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) ax_q[i] <= '0;
      ax4_q       <= '0;
      ax5_q       <= '0;
      btn_q       <= '0;
      for (int i = 0; i < 4; i++) out_ax_q[i] <= '0;
      out_ax4_q   <= '0;
      out_ax5_q   <= '0;
      out_btn_q   <= '0;
      out_src_q   <= 1'b0;
      out_kind_q  <= '0;
      out_ok_q    <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!frame_stall_i) out_valid_q <= 1'b0;
      if (out_load) begin
        for (int i = 0; i < 4; i++) out_ax_q[i] <= ax_q[i];
        out_ax4_q  <= ax4_q;
        out_ax5_q  <= ax5_q;
        out_btn_q  <= btn_q;
        out_src_q  <= src_q;
        out_kind_q <= kind_q;
        out_ok_q   <= ok_q;
      end
      case (state_q)
        StIdle: begin
          if (rx_valid_i && !rx_stall_o) begin
            fill_q <= fill_q + 4'd1;
            if (fill_q == 4'(rcfd_pkg::WinLen - 1)) state_q <= StDecode;
          end
        end
        StDecode: begin
          src_q <= (win_q[0] == rcfd_pkg::HdrB);
          if (crc_req.start) begin
            kind_q  <= (win_q[2] == rcfd_pkg::KindJoy) ? rcfd_pkg::FkJoy :
                       (win_q[2] == rcfd_pkg::KindBtn) ? rcfd_pkg::FkBtn : rcfd_pkg::FkKnob;
            len_q   <= crc_req.count + 4'd1;
            state_q <= StCrc;
          end else begin
            shift_q <= 4'd1;
            emit_q  <= 1'b0;
            state_q <= StShift;
          end
        end
        StCrc: begin
          if (crc_rsp.done) begin
            ok_q    <= (crc_rsp.crc == win_q[len_q - 4'd1]);
            state_q <= StApply;
          end
        end
        StApply: begin
          if (ok_q) begin
            case (kind_q)
              rcfd_pkg::FkJoy: begin
                if (win_q[4] == 8'd1) begin
                  ax_q[0] <= -stick(win_q[5], win_q[6]);
                  ax_q[1] <= stick(win_q[7], win_q[8]);
                end else if (win_q[4] == 8'd2) begin
                  ax_q[2] <= stick(win_q[7], win_q[8]);
                  ax_q[3] <= stick(win_q[5], win_q[6]);
                end
              end
              rcfd_pkg::FkBtn: begin
                if (!src_q) begin
                  btn_q[5] <= (win_q[9] == 8'd0);
                end else begin
                  btn_q[10] <= (win_q[7] == 8'd0);
                  btn_q[6]  <= (win_q[7] == 8'd0);
                  btn_q[7]  <= (win_q[10] == 8'd0);
                  btn_q[4]  <= (win_q[6] == 8'd0);
                  btn_q[1]  <= (win_q[8] == 8'd0);
                end
              end
              default: begin
                if (!src_q) begin
                  btn_q[5] <= d6[0];
                  btn_q[7] <= d6[1];
                end else begin
                  ax5_q <= d6[0] ? $signed({1'b0, rcfd_pkg::KnobFull}) :
                           d6[1] ? -$signed({1'b0, rcfd_pkg::KnobFull}) : 10'sd0;
                  ax4_q <= d3[0] ? -$signed({1'b0, rcfd_pkg::KnobFull}) :
                           d3[1] ? $signed({1'b0, rcfd_pkg::KnobFull}) : 10'sd0;
                  btn_q[3]  <= d5[0];
                  btn_q[11] <= d5[1];
                  btn_q[9]  <= d4[0];
                  btn_q[2]  <= d4[0];
                  btn_q[8]  <= d4[1];
                  btn_q[0]  <= d4[1];
                end
              end
            endcase
          end
          shift_q <= len_q;
          emit_q  <= 1'b1;
          state_q <= StShift;
        end
        StShift: begin
          fill_q  <= fill_q - 4'd1;
          shift_q <= shift_q - 4'd1;
          if (shift_q == 4'd1) state_q <= emit_q ? StOut : StIdle;
        end
        StOut: begin
          // Hold here until the result register is free.
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign axis_left_x_o  = out_ax_q[0];
  assign axis_left_y_o  = out_ax_q[1];
  assign axis_right_x_o = out_ax_q[2];
  assign axis_right_y_o = out_ax_q[3];
  assign axis_camera_o  = out_ax4_q;
  assign axis_linear_o  = out_ax5_q;
  assign button_bits_o  = out_btn_q;
  assign frame_source_o = out_src_q;
  assign frame_kind_o   = out_kind_q;
  assign check_ok_o     = out_ok_q;

`include "remote_control_frame_decoder_macros.svh"

  // The window never overfills.
  `RCFD_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= 4'(rcfd_pkg::WinLen), "window overfilled")
  // A stalled result stays valid and keeps its payload.
  `RCFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && frame_stall_i, out_valid_q && $stable(button_bits_o) && $stable(frame_kind_o), "stalled result changed")
  // The output step is always followed by a valid result.
  `RCFD_ASSERT_NEXT(a_out_step, clk_i, rst_ni, state_q == StOut, out_valid_q, "result lost")
endmodule
